/* design/pee_pkg.sv */
`default_nettype none

package pee_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    localparam int DATA_W   = 32;
    localparam int SYM_W    = 8;
    localparam int DEPTH_W  = 5;
    localparam int STATUS_W = 3;

    // ascii codes that mean something to the evaluator
    localparam logic [SYM_W-1:0] SYM_DIGIT_LO = 8'd48;
    localparam logic [SYM_W-1:0] SYM_DIGIT_HI = 8'd57;
    localparam logic [SYM_W-1:0] SYM_PLUS     = 8'd43;
    localparam logic [SYM_W-1:0] SYM_MINUS    = 8'd45;
    localparam logic [SYM_W-1:0] SYM_STAR     = 8'd42;
    localparam logic [SYM_W-1:0] SYM_SLASH    = 8'd47;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_UNDER   = 3'd1,
        ST_OVER    = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_BADSYM  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

endpackage

`default_nettype wire

/* design/pee_alu.sv */
`default_nettype none

module pee_alu (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire pee_pkg::t_alu_req        i_req,
    input  wire logic [pee_pkg::DATA_W-1:0] i_a,
    input  wire logic [pee_pkg::DATA_W-1:0] i_b,
    output logic                          o_done,
    output logic [pee_pkg::DATA_W-1:0]    o_result
);
    import pee_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ABS_A,
        S_ABS_B,
        S_DIV,
        S_SIGN,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [DATA_W-1:0]   r_x;     // accumulator or partial remainder
    logic [DATA_W-1:0]   r_y;     // multiplicand or divisor magnitude
    logic [DATA_W-1:0]   r_q;     // multiplier or dividend / quotient
    logic [CNT_W-1:0]    r_cnt;
    logic                r_neg;

    // the one shared adder / subtractor
    logic [DATA_W-1:0]   w_add_x;
    logic [DATA_W-1:0]   w_add_y;
    logic                w_add_sub;
    logic [DATA_W:0]     w_sum;

    always_comb begin
        w_add_x   = '0;
        w_add_y   = r_q;
        w_add_sub = 1'b1;
        case (r_state)
            S_IDLE: begin
                w_add_x   = i_a;
                w_add_y   = i_b;
                w_add_sub = (i_req.op == ALU_SUB);
            end
            S_MUL: begin
                w_add_x   = r_x;
                w_add_y   = r_y;
                w_add_sub = 1'b0;
            end
            S_ABS_A: begin
                w_add_y = r_q;
            end
            S_ABS_B: begin
                w_add_y = r_y;
            end
            S_DIV: begin
                w_add_x = {r_x[DATA_W-2:0], r_q[DATA_W-1]};
                w_add_y = r_y;
            end
            S_SIGN: begin
                w_add_y = r_q;
            end
            default: begin
                w_add_x = '0;
            end
        endcase
        // carry out of a subtract is high when there is no borrow
        w_sum = {1'b0, w_add_x}
              + {1'b0, (w_add_sub ? ~w_add_y : w_add_y)}
              + {{DATA_W{1'b0}}, w_add_sub};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_cnt <= '0;
                        case (i_req.op)
                            ALU_ADD, ALU_SUB: begin
                                r_x     <= w_sum[DATA_W-1:0];
                                r_state <= S_FIN;
                            end
                            ALU_MUL: begin
                                r_x     <= '0;
                                r_y     <= i_a;
                                r_q     <= i_b;
                                r_state <= S_MUL;
                            end
                            default: begin
                                r_q     <= i_a;
                                r_y     <= i_b;
                                r_neg   <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
                                r_state <= S_ABS_A;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    if (r_q[0]) begin
                        r_x <= w_sum[DATA_W-1:0];
                    end
                    r_y   <= {r_y[DATA_W-2:0], 1'b0};
                    r_q   <= {1'b0, r_q[DATA_W-1:1]};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_ABS_A: begin
                    if (r_q[DATA_W-1]) begin
                        r_q <= w_sum[DATA_W-1:0];
                    end
                    r_state <= S_ABS_B;
                end
                S_ABS_B: begin
                    if (r_y[DATA_W-1]) begin
                        r_y <= w_sum[DATA_W-1:0];
                    end
                    r_x     <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring step: keep the difference only when it did not borrow
                    if (w_sum[DATA_W]) begin
                        r_x <= w_sum[DATA_W-1:0];
                    end else begin
                        r_x <= w_add_x;
                    end
                    r_q   <= {r_q[DATA_W-2:0], w_sum[DATA_W]};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_SIGN;
                    end
                end
                S_SIGN: begin
                    r_x     <= r_neg ? w_sum[DATA_W-1:0] : r_q;
                    r_state <= S_FIN;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done   = (r_state == S_FIN);
    assign o_result = r_x;

endmodule

`default_nettype wire

/* design/postfix_expression_evaluator.sv */
`default_nettype none

// postfix expression evaluator: each input transfer carries one ascii symbol
// (tdata) and a clear flag (tuser). a digit '0'..'9' pushes its value, an
// operator + - * / pops b and replaces the next value a with a op b, using
// 32-bit wrapping arithmetic with division truncated toward zero. every
// symbol yields exactly one output transfer with the top value (0 when the
// stack is empty), the depth and a status code: 0 ok, 1 underflow,
// 2 overflow, 3 divide by zero, 4 bad symbol. on any error the stack is left
// as it was, but a clear asked for on the same transfer still happens.
// timing: the block takes one symbol at a time. a digit, an error or a clear
// goes straight from the idle state to the done state, + and - pass through
// the read and wait states for one add or subtract in the arithmetic unit,
// while * and / use the shared adder there one bit per cycle (32 shift-add or
// restoring steps, plus two magnitude steps and a sign fix for /). the output
// is registered, so a new symbol is taken while an earlier result still waits;
// a finished result that finds the output still full holds the block until
// the earlier one is taken.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] symbol
    input  wire logic        i_s_axis_tuser,   // [0] clear_first
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata    // [31:0] top_value, [36:32] stack_depth,
                                               // [39:37] status
);
    import pee_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);
    localparam logic [DW-1:0] DEPTH_TWO  = DW'(2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_DONE
    } t_state;

    // operand stack, entries below the depth are always written
    logic [DATA_W-1:0] r_stack [STACK_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    t_state            r_state, n_state;
    logic [DW-1:0]     r_depth, n_depth;
    logic [DATA_W-1:0] r_top,   n_top;      // copy of the top entry
    t_status           r_status, n_status;
    t_alu_op           r_op,    n_op;
    logic [DATA_W-1:0] r_b,     n_b;
    logic              r_out_valid;
    logic [39:0]       r_out_data;

    logic              w_accept;
    logic [DW-1:0]     w_depth_eff;
    logic [DW-1:0]     w_a_idx_eff;
    logic [DW-1:0]     w_a_idx_cur;
    logic              w_is_digit;
    logic              w_is_op;
    t_alu_op           w_sym_op;
    logic [3:0]        w_digit;
    logic              w_slot_free;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic [AW-1:0]     w_raddr;

    t_alu_req          w_alu_req;
    logic              w_alu_done;
    logic [DATA_W-1:0] w_alu_result;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_slot_free     = !r_out_valid || i_m_axis_tready;

    // clear takes effect before the symbol is handled
    assign w_depth_eff = i_s_axis_tuser ? '0 : r_depth;
    assign w_a_idx_eff = w_depth_eff - DEPTH_TWO;
    assign w_a_idx_cur = r_depth - DEPTH_TWO;
    assign w_digit     = 4'(i_s_axis_tdata - SYM_DIGIT_LO);

    always_comb begin
        w_is_digit = i_s_axis_tdata inside {[SYM_DIGIT_LO:SYM_DIGIT_HI]};
        w_is_op    = 1'b1;
        case (i_s_axis_tdata)
            SYM_PLUS:  w_sym_op = ALU_ADD;
            SYM_MINUS: w_sym_op = ALU_SUB;
            SYM_STAR:  w_sym_op = ALU_MUL;
            SYM_SLASH: w_sym_op = ALU_DIV;
            default: begin
                w_sym_op = ALU_ADD;
                w_is_op  = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state   = r_state;
        n_depth   = r_depth;
        n_top     = r_top;
        n_status  = r_status;
        n_op      = r_op;
        n_b       = r_b;
        w_we      = 1'b0;
        w_waddr   = w_depth_eff[AW-1:0];
        w_wdata   = {{(DATA_W-4){1'b0}}, w_digit};
        w_raddr   = w_a_idx_eff[AW-1:0];
        w_alu_req = '{start: 1'b0, op: r_op};
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_depth = w_depth_eff;
                    n_state = S_DONE;
                    if (w_is_digit) begin
                        if (w_depth_eff == DEPTH_FULL) begin
                            n_status = ST_OVER;
                        end else begin
                            w_we     = 1'b1;
                            n_top    = w_wdata;
                            n_depth  = w_depth_eff + DW'(1);
                            n_status = ST_OK;
                        end
                    end else if (w_is_op) begin
                        if (w_depth_eff < DEPTH_TWO) begin
                            n_status = ST_UNDER;
                        end else if (w_sym_op == ALU_DIV && r_top == '0) begin
                            n_status = ST_DIVZERO;
                        end else begin
                            // b is the cached top, a comes from the stack read
                            n_status = ST_OK;
                            n_op     = w_sym_op;
                            n_b      = r_top;
                            n_state  = S_READ;
                        end
                    end else begin
                        n_status = ST_BADSYM;
                    end
                end
            end
            S_READ: begin
                w_alu_req = '{start: 1'b1, op: r_op};
                n_state   = S_WAIT;
            end
            S_WAIT: begin
                if (w_alu_done) begin
                    w_we    = 1'b1;
                    w_waddr = w_a_idx_cur[AW-1:0];
                    w_wdata = w_alu_result;
                    n_top   = w_alu_result;
                    n_depth = r_depth - DW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // stack memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_stack[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_stack[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_depth  <= n_depth;
            r_top    <= n_top;
            r_status <= n_status;
            r_op     <= n_op;
            r_b      <= n_b;
            if (r_state == S_DONE && w_slot_free) begin
                r_out_valid <= 1'b1;
                r_out_data  <= {r_status, DEPTH_W'(r_depth),
                                (r_depth == '0) ? {DATA_W{1'b0}} : r_top};
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    pee_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_alu_req),
        .i_a      (r_rd_data),
        .i_b      (r_b),
        .o_done   (w_alu_done),
        .o_result (w_alu_result)
    );

endmodule

`default_nettype wire
